>>> rtl/slcd_pkg.sv
package slcd_pkg;

   localparam logic [2:0] CMD_BIG     = 3'd0;
   localparam logic [2:0] CMD_SMALL   = 3'd1;
   localparam logic [2:0] CMD_UNIT    = 3'd2;
   localparam logic [2:0] CMD_SMILEY  = 3'd3;
   localparam logic [2:0] CMD_LINK    = 3'd4;
   localparam logic [2:0] CMD_BATTERY = 3'd5;

   localparam logic [7:0] SYM_HI_A = 8'h67;
   localparam logic [7:0] SYM_HI_B = 8'h40;
   localparam logic [7:0] SYM_LO_A = 8'hE0;
   localparam logic [7:0] SYM_LO_B = 8'hC6;
   localparam logic [7:0] SEG_ZERO = 8'hF5;
   localparam logic [7:0] SEG_MINUS = 8'h02;
   localparam logic [7:0] SEG_POINT = 8'h08;

   localparam int SEG_BYTES = 6;

   // Raw request word as accepted.
   typedef struct packed {
      logic [2:0]         command;
      logic signed [15:0] number;
      logic               percent;
      logic [7:0]         symbol;
      logic [2:0]         pattern;
   } req_type;

   // Classified value with the magnitude to be shown.
   typedef struct packed {
      logic [2:0]  command;
      logic        percent;
      logic [7:0]  symbol;
      logic [2:0]  pattern;
      logic        hi;
      logic        lo;
      logic        neg;
      logic        point;
      logic [10:0] mag;
   } cls_type;

   // Magnitude split into tens quotient and ones digit.
   typedef struct packed {
      logic [2:0] command;
      logic       percent;
      logic [7:0] symbol;
      logic [2:0] pattern;
      logic       hi;
      logic       lo;
      logic       neg;
      logic       point;
      logic       gt999;
      logic       gt99;
      logic       gt9;
      logic [7:0] quot;
      logic [3:0] ones;
   } dig_type;

   function automatic logic [7:0] seg_digit(input logic [3:0] d);
      logic [7:0] code;
      unique case (d)
         4'd0: code = 8'hF5;
         4'd1: code = 8'h05;
         4'd2: code = 8'hD3;
         4'd3: code = 8'h97;
         4'd4: code = 8'h27;
         4'd5: code = 8'hB6;
         4'd6: code = 8'hF6;
         4'd7: code = 8'h15;
         4'd8: code = 8'hF7;
         4'd9: code = 8'hB7;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

>>> rtl/segment_lcd_buffer_composer_top.sv
// Segment buffer composer for a seven-segment LCD.
// The request channel (req_valid / req_stall) carries one command word: a
// big number in tenths, a small number, a unit symbol, the smiley, the link
// icon or the battery icon. Each accepted word updates the six-byte segment
// buffer by read-modify-write, and the response channel (rsp_valid /
// rsp_stall) returns all six buffer bytes after that update, one response
// word per request word, in order.
// An accepted request word passes the input register, then sign/range
// classification with rounding to whole units, the tens split, then digit
// extraction merged into the buffer; rsp_valid rises as the buffer register,
// which is the response register, takes it. One word is accepted per cycle
// while req_stall is low. Synchronous reset blanks the buffer (all zeros)
// and empties the pipeline. While rsp_stall is high the response holds; the
// pipeline keeps filling until all three internal stages hold a word, and
// only then is req_stall raised.
module segment_lcd_buffer_composer_top
   import slcd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_command,
   input  logic signed [15:0] req_number,
   input  logic               req_percent,
   input  logic [7:0]         req_symbol,
   input  logic [2:0]         req_pattern,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_seg_byte0,
   output logic [7:0]         rsp_seg_byte1,
   output logic [7:0]         rsp_seg_byte2,
   output logic [7:0]         rsp_seg_byte3,
   output logic [7:0]         rsp_seg_byte4,
   output logic [7:0]         rsp_seg_byte5
);

   logic    s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   req_type s1_ff;
   cls_type s2_ff, s2_in;
   dig_type s3_ff, s3_in;
   logic [7:0] seg_ff [SEG_BYTES];
   logic [7:0] seg_in [SEG_BYTES];

   logic adv_out, move3, move2, accept;

   assign adv_out   = s3_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign move3     = s2_valid_ff && (!s3_valid_ff || adv_out);
   assign move2     = s1_valid_ff && (!s2_valid_ff || move3);
   assign req_stall = s1_valid_ff && !move2;
   assign accept    = req_valid && !req_stall;

   // Classification and rounding.
   logic [15:0] abs_val, rsum;
   logic [31:0] rprod;
   logic        big_round;

   always_comb begin
      abs_val   = s1_ff.number[15] ? 16'(-s1_ff.number) : 16'(s1_ff.number);
      rsum      = abs_val + 16'd5;
      // (x + 5) / 10 for x + 5 up to 20000, via reciprocal 52429 / 2^19.
      rprod     = 32'(rsum) * 32'd52429;
      big_round = (s1_ff.number > 16'sd1995) || (s1_ff.number < -16'sd95);

      s2_in.command = s1_ff.command;
      s2_in.percent = s1_ff.percent;
      s2_in.symbol  = s1_ff.symbol;
      s2_in.pattern = s1_ff.pattern;
      s2_in.neg     = s1_ff.number[15];
      s2_in.point   = !big_round;
      if (s1_ff.command == CMD_BIG) begin
         s2_in.hi  = s1_ff.number > 16'sd19995;
         s2_in.lo  = s1_ff.number < -16'sd995;
         s2_in.mag = big_round ? rprod[29:19] : abs_val[10:0];
      end else begin
         s2_in.hi  = s1_ff.number > 16'sd99;
         s2_in.lo  = s1_ff.number < -16'sd9;
         s2_in.mag = abs_val[10:0];
      end
   end

   // Tens split of the magnitude.
   logic [21:0] qprod;
   logic [7:0]  quot;
   logic [10:0] quot_x10;

   always_comb begin
      // m / 10 for m up to 2000, via reciprocal 1639 / 2^14.
      qprod    = 22'(s2_ff.mag) * 22'd1639;
      quot     = qprod[21:14];
      quot_x10 = {quot, 3'b000} + 11'({quot, 1'b0});

      s3_in.command = s2_ff.command;
      s3_in.percent = s2_ff.percent;
      s3_in.symbol  = s2_ff.symbol;
      s3_in.pattern = s2_ff.pattern;
      s3_in.hi      = s2_ff.hi;
      s3_in.lo      = s2_ff.lo;
      s3_in.neg     = s2_ff.neg;
      s3_in.point   = s2_ff.point;
      s3_in.gt999   = s2_ff.mag > 11'd999;
      s3_in.gt99    = s2_ff.mag > 11'd99;
      s3_in.gt9     = s2_ff.mag > 11'd9;
      s3_in.quot    = quot;
      s3_in.ones    = 4'(s2_ff.mag - quot_x10);
   end

   // Digit extraction and merge into the buffer.
   logic [15:0] hprod;
   logic [4:0]  hquot;
   logic [3:0]  tens, hund;
   logic [7:0]  ones_code;

   always_comb begin
      // q / 10 for q up to 200, via reciprocal 205 / 2^11.
      hprod     = 16'(s3_ff.quot) * 16'd205;
      hquot     = hprod[15:11];
      tens      = 4'(s3_ff.quot - 8'({hquot, 3'b000}) - 8'({hquot, 1'b0}));
      if (hquot >= 5'd20) begin
         hund = 4'(hquot - 5'd20);
      end else if (hquot >= 5'd10) begin
         hund = 4'(hquot - 5'd10);
      end else begin
         hund = hquot[3:0];
      end
      ones_code = seg_digit(s3_ff.ones);

      seg_in = seg_ff;
      unique case (s3_ff.command)
         CMD_BIG: begin
            seg_in[2] = seg_ff[2] & SEG_POINT;
            if (s3_ff.hi) begin
               seg_in[0] = SYM_HI_A;
               seg_in[1] = SYM_HI_B;
            end else if (s3_ff.lo) begin
               seg_in[0] = SYM_LO_A;
               seg_in[1] = SYM_LO_B;
            end else begin
               seg_in[0] = s3_ff.neg ? SEG_MINUS : 8'h00;
               seg_in[1] = s3_ff.point ? SEG_POINT : 8'h00;
               if (s3_ff.gt999) seg_in[0] = seg_in[0] | 8'h08;
               if (s3_ff.gt99)  seg_in[0] = seg_in[0] | seg_digit(hund);
               seg_in[1] = seg_in[1] | (s3_ff.gt9 ? seg_digit(tens) : SEG_ZERO);
               seg_in[2] = seg_in[2] | ones_code;
            end
         end
         CMD_SMALL: begin
            seg_in[4] = seg_ff[4] & 8'h08;
            seg_in[5] = s3_ff.percent ? 8'h08 : 8'h00;
            if (s3_ff.hi) begin
               seg_in[4] = seg_in[4] | SYM_HI_A;
               seg_in[5] = seg_in[5] | SYM_HI_B;
            end else if (s3_ff.lo) begin
               seg_in[4] = seg_in[4] | SYM_LO_A;
               seg_in[5] = seg_in[5] | SYM_LO_B;
            end else begin
               if (s3_ff.neg) seg_in[4] = seg_in[4] | SEG_MINUS;
               if (s3_ff.gt9) seg_in[4] = seg_in[4] | seg_digit(tens);
               seg_in[5] = seg_in[5] | ones_code;
            end
         end
         CMD_UNIT: begin
            seg_in[3] = {s3_ff.symbol[6], s3_ff.symbol[5], seg_ff[3][5:0]};
            seg_in[2] = {seg_ff[2][7:4], s3_ff.symbol[7], seg_ff[2][2:0]};
         end
         CMD_SMILEY: begin
            seg_in[3] = {seg_ff[3][7:5], s3_ff.pattern[2], seg_ff[3][3:2],
                         s3_ff.pattern[1], s3_ff.pattern[0]};
         end
         CMD_LINK: begin
            seg_in[4] = {seg_ff[4][7:4], s3_ff.pattern[0], seg_ff[4][2:0]};
         end
         CMD_BATTERY: begin
            seg_in[3] = {seg_ff[3][7:6], s3_ff.pattern[0], seg_ff[3][4:0]};
         end
         default: begin
            seg_in = seg_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SEG_BYTES; i++) begin
            seg_ff[i] <= 8'h00;
         end
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (move2) begin
            s1_valid_ff <= 1'b0;
         end
         if (move2) begin
            s2_valid_ff <= 1'b1;
         end else if (move3) begin
            s2_valid_ff <= 1'b0;
         end
         if (move3) begin
            s3_valid_ff <= 1'b1;
         end else if (adv_out) begin
            s3_valid_ff <= 1'b0;
         end
         if (adv_out) begin
            rsp_valid_ff <= 1'b1;
            seg_ff       <= seg_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= '{command: req_command, number: req_number, percent: req_percent,
                    symbol: req_symbol, pattern: req_pattern};
      end
      if (move2) begin
         s2_ff <= s2_in;
      end
      if (move3) begin
         s3_ff <= s3_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_seg_byte0 = seg_ff[0];
   assign rsp_seg_byte1 = seg_ff[1];
   assign rsp_seg_byte2 = seg_ff[2];
   assign rsp_seg_byte3 = seg_ff[3];
   assign rsp_seg_byte4 = seg_ff[4];
   assign rsp_seg_byte5 = seg_ff[5];

endmodule

>>> rtl/slcd_checker.sv
module slcd_checker
   import slcd_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [7:0]         rsp_seg_byte0,
   input logic [7:0]         rsp_seg_byte1,
   input logic [7:0]         rsp_seg_byte2,
   input logic [7:0]         rsp_seg_byte3,
   input logic [7:0]         rsp_seg_byte4,
   input logic [7:0]         rsp_seg_byte5
);

   logic [8*SEG_BYTES-1:0] bytes;
   assign bytes = {rsp_seg_byte5, rsp_seg_byte4, rsp_seg_byte3,
                   rsp_seg_byte2, rsp_seg_byte1, rsp_seg_byte0};

   // A stalled response word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(bytes))
      else $error("stalled response word changed");

   // Reset empties the pipeline and blanks the display.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && bytes == '0)
      else $error("reset did not blank the buffer");

   // The buffer only changes when a new response word is presented.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(bytes) |-> rsp_valid)
      else $error("buffer changed without a response word");

   // With the response register free, the pipeline always drains.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while the response register is empty");

endmodule

bind segment_lcd_buffer_composer_top slcd_checker u_checker (.*);

>>> dv/segment_lcd_buffer_composer_top_test.sv
`timescale 1ns / 100ps

module segment_lcd_buffer_composer_top_test;
   import slcd_pkg::*;

   // Command codes the block leaves unused; they must not touch the buffer.
   localparam logic [2:0] CMD_SPARE6 = 3'd6;
   localparam logic [2:0] CMD_SPARE7 = 3'd7;
   localparam logic [7:0] SEG_LEAD_ONE = 8'h08;
   localparam logic [7:0] SEG_PERCENT = 8'h08;
   localparam int HOLD_CYCLES = 150;
   localparam int DRAIN_CYCLES = 8;

   typedef logic [SEG_BYTES-1:0][7:0] frame_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [2:0]          req_command = CMD_BIG;
   logic signed [15:0]  req_number = '0;
   logic                req_percent = 1'b0;
   logic [7:0]          req_symbol = '0;
   logic [2:0]          req_pattern = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [7:0]          rsp_seg_byte0;
   logic [7:0]          rsp_seg_byte1;
   logic [7:0]          rsp_seg_byte2;
   logic [7:0]          rsp_seg_byte3;
   logic [7:0]          rsp_seg_byte4;
   logic [7:0]          rsp_seg_byte5;

   frame_type  lcd_image = '0;
   frame_type  frame_q[$];
   bit         idle_on = 1'b1;
   bit         hold_request = 1'b0;
   int         mismatch_count = 0;
   int         words_checked = 0;
   int         cmd_tally[8];

   segment_lcd_buffer_composer_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_number    (req_number),
      .req_percent   (req_percent),
      .req_symbol    (req_symbol),
      .req_pattern   (req_pattern),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_seg_byte0 (rsp_seg_byte0),
      .rsp_seg_byte1 (rsp_seg_byte1),
      .rsp_seg_byte2 (rsp_seg_byte2),
      .rsp_seg_byte3 (rsp_seg_byte3),
      .rsp_seg_byte4 (rsp_seg_byte4),
      .rsp_seg_byte5 (rsp_seg_byte5)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] digit_segs(input int d);
      logic [7:0] segs;
      case (d)
         0: segs = 8'hF5;
         1: segs = 8'h05;
         2: segs = 8'hD3;
         3: segs = 8'h97;
         4: segs = 8'h27;
         5: segs = 8'hB6;
         6: segs = 8'hF6;
         7: segs = 8'h15;
         8: segs = 8'hF7;
         default: segs = 8'hB7;
      endcase
      return segs;
   endfunction

   // Applies one command word to a copy of the display image.
   function automatic frame_type compose_frame(input frame_type f, input logic [2:0] cmd,
                                               input logic signed [15:0] num, input logic pct,
                                               input logic [7:0] sym, input logic [2:0] pat);
      int n;
      bit whole_units;
      n = num;
      case (cmd)
         CMD_BIG: begin
            f[2] &= SEG_POINT;
            if (n > 19995) begin
               f[0] = SYM_HI_A;
               f[1] = SYM_HI_B;
            end else if (n < -995) begin
               f[0] = SYM_LO_A;
               f[1] = SYM_LO_B;
            end else begin
               // Large values drop the decimal and are rounded to whole units.
               whole_units = (n > 1995) || (n < -95);
               f[0] = 8'h00;
               f[1] = whole_units ? 8'h00 : SEG_POINT;
               if (n < 0) begin
                  n = -n;
                  f[0] = SEG_MINUS;
               end
               if (whole_units)
                  n = (n + 5) / 10;
               if (n > 999)
                  f[0] |= SEG_LEAD_ONE;
               if (n > 99)
                  f[0] |= digit_segs((n / 100) % 10);
               f[1] |= (n > 9) ? digit_segs((n / 10) % 10) : SEG_ZERO;
               f[2] |= digit_segs(n % 10);
            end
         end
         CMD_SMALL: begin
            f[4] &= 8'h08;
            f[5] = pct ? SEG_PERCENT : 8'h00;
            if (n > 99) begin
               f[4] |= SYM_HI_A;
               f[5] |= SYM_HI_B;
            end else if (n < -9) begin
               f[4] |= SYM_LO_A;
               f[5] |= SYM_LO_B;
            end else begin
               if (n < 0) begin
                  n = -n;
                  f[4] |= SEG_MINUS;
               end
               if (n > 9)
                  f[4] |= digit_segs(n / 10);
               f[5] |= digit_segs(n % 10);
            end
         end
         CMD_UNIT: begin
            f[3][6] = sym[5];
            f[3][7] = sym[6];
            f[2][3] = sym[7];
         end
         CMD_SMILEY: begin
            f[3][0] = pat[0];
            f[3][1] = pat[1];
            f[3][4] = pat[2];
         end
         CMD_LINK:    f[4][3] = pat[0];
         CMD_BATTERY: f[3][5] = pat[0];
         default: ;
      endcase
      return f;
   endfunction

   // Offers one command word and waits until the block takes it.
   task automatic send_word(input logic [2:0] cmd, input logic [15:0] num, input logic pct,
                            input logic [7:0] sym, input logic [2:0] pat);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_number  <= num;
      req_percent <= pct;
      req_symbol  <= sym;
      req_pattern <= pat;
      do
         @(posedge clock);
      while (req_stall);
      lcd_image = compose_frame(lcd_image, cmd, num, pct, sym, pat);
      frame_q.push_back(lcd_image);
      cmd_tally[cmd]++;
   endtask

   task automatic send_random(input int count);
      int sel;
      int n;
      logic [2:0] cmd;
      for (int k = 0; k < count; k++) begin
         sel = $urandom_range(0, 99);
         if (sel < 35)
            cmd = CMD_BIG;
         else if (sel < 65)
            cmd = CMD_SMALL;
         else if (sel < 73)
            cmd = CMD_UNIT;
         else if (sel < 81)
            cmd = CMD_SMILEY;
         else if (sel < 88)
            cmd = CMD_LINK;
         else if (sel < 95)
            cmd = CMD_BATTERY;
         else
            cmd = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;

         sel = $urandom_range(0, 9);
         if (sel >= 8) begin
            n = $urandom_range(0, 65535) - 32768;
         end else if (cmd == CMD_SMALL) begin
            if (sel < 3) begin
               case ($urandom_range(0, 3))
                  0: n = 99;
                  1: n = -9;
                  2: n = 9;
                  default: n = 0;
               endcase
               n += $urandom_range(0, 6) - 3;
            end else begin
               n = $urandom_range(0, 125) - 15;
            end
         end else begin
            if (sel < 3) begin
               case ($urandom_range(0, 8))
                  0: n = 19995;
                  1: n = -995;
                  2: n = 1995;
                  3: n = -95;
                  4: n = 999;
                  5: n = 99;
                  6: n = 9;
                  7: n = -9;
                  default: n = 0;
               endcase
               n += $urandom_range(0, 6) - 3;
            end else begin
               n = $urandom_range(0, 22400) - 1200;
            end
         end
         send_word(cmd, 16'(n), 1'($urandom), 8'($urandom), 3'($urandom));
      end
   endtask

   task automatic test_directed_values;
      // An unused code straight after reset shows the blank buffer.
      send_word(CMD_SPARE6, 16'h7FFF, 1'b1, 8'hFF, 3'h7);
      send_word(CMD_BIG, 16'sd0, 1'b0, 8'h00, 3'h0);
      send_word(CMD_BIG, 16'sd19995, 1'b0, 8'h00, 3'h0);
      send_word(CMD_BIG, 16'sd19996, 1'b1, 8'hFF, 3'h7);
      send_word(CMD_BIG, -16'sd995, 1'b0, 8'h00, 3'h0);
      send_word(CMD_BIG, -16'sd996, 1'b0, 8'h00, 3'h0);
      send_word(CMD_BIG, 16'sd1995, 1'b0, 8'h00, 3'h0);
      send_word(CMD_BIG, 16'sd1996, 1'b0, 8'h00, 3'h0);
      send_word(CMD_BIG, -16'sd95, 1'b0, 8'h00, 3'h0);
      send_word(CMD_BIG, -16'sd96, 1'b0, 8'h00, 3'h0);
      send_word(CMD_BIG, 16'sd32767, 1'b0, 8'h00, 3'h0);
      send_word(CMD_BIG, -16'sd32768, 1'b0, 8'h00, 3'h0);
      send_word(CMD_BIG, 16'sd9, 1'b0, 8'h00, 3'h0);
      send_word(CMD_SMALL, 16'sd99, 1'b1, 8'h00, 3'h0);
      send_word(CMD_SMALL, 16'sd100, 1'b0, 8'h00, 3'h0);
      send_word(CMD_SMALL, -16'sd9, 1'b0, 8'h00, 3'h0);
      send_word(CMD_SMALL, -16'sd10, 1'b1, 8'h00, 3'h0);
      send_word(CMD_SMALL, 16'sd10, 1'b0, 8'h00, 3'h0);
      send_word(CMD_UNIT, 16'sd0, 1'b0, 8'hE0, 3'h0);
      send_word(CMD_SMILEY, 16'sd0, 1'b0, 8'h00, 3'h7);
      send_word(CMD_LINK, 16'sd0, 1'b0, 8'h00, 3'h1);
      send_word(CMD_BATTERY, 16'sd0, 1'b0, 8'h00, 3'h1);
      send_word(CMD_UNIT, 16'sd0, 1'b0, 8'h1F, 3'h0);
      send_word(CMD_SMILEY, 16'sd0, 1'b0, 8'h00, 3'h2);
      send_word(CMD_LINK, 16'sd0, 1'b0, 8'h00, 3'h6);
      send_word(CMD_BATTERY, 16'sd0, 1'b0, 8'h00, 3'h6);
      send_word(CMD_SPARE7, -16'sd1, 1'b1, 8'hFF, 3'h7);
   endtask

   task automatic test_random_traffic;
      send_random(850);
   endtask

   // The output side stops for a long stretch so the pipeline fills and the
   // block has to stall its input.
   task automatic test_output_hold_off;
      for (int r = 0; r < 2; r++) begin
         hold_request = 1'b1;
         send_random(16);
         while (hold_request)
            @(posedge clock);
      end
   endtask

   task automatic test_back_to_back;
      idle_on = 1'b0;
      send_random(120);
   endtask

   initial begin : rsp_stall_driver
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            for (int span = 0; span < HOLD_CYCLES; span++)
               @(posedge clock);
            rsp_stall <= 1'b0;
            hold_request = 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : rsp_checker
      frame_type seen;
      frame_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_seg_byte5, rsp_seg_byte4, rsp_seg_byte3,
                 rsp_seg_byte2, rsp_seg_byte1, rsp_seg_byte0};
         if (frame_q.size() == 0) begin
            $error("buffer word with no command pending: %012h", seen);
            mismatch_count++;
         end else begin
            want = frame_q.pop_front();
            words_checked++;
            for (int i = 0; i < SEG_BYTES; i++) begin
               if (seen[i] !== want[i]) begin
                  $error("seg_byte%0d expected %02h actual %02h", i, want[i], seen[i]);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin : watchdog
      #(5_000_000);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_values;
      test_random_traffic;
      test_output_hold_off;
      test_back_to_back;
      req_valid <= 1'b0;

      while (frame_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d buffer words: %0d big numbers, %0d small numbers, %0d icon updates,",
               words_checked, cmd_tally[CMD_BIG], cmd_tally[CMD_SMALL],
               cmd_tally[CMD_UNIT] + cmd_tally[CMD_SMILEY] + cmd_tally[CMD_LINK]
               + cmd_tally[CMD_BATTERY]);
      $display("%0d unused codes, with random gaps, two long output hold-offs and a gapless run.",
               cmd_tally[CMD_SPARE6] + cmd_tally[CMD_SPARE7]);
      if (mismatch_count == 0 && frame_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
